/* src/scl_pkg.sv */
package scl_pkg;

  // Store sizes.
  localparam int CMD_LEN    = 8;
  localparam int NUM_DIGITS = 5;

  localparam int POS_W      = 4;
  localparam int CMD_IDX_W  = (CMD_LEN > 1) ? $clog2(CMD_LEN) : 1;
  localparam int DIG_IDX_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  localparam int BYTE_W     = 8;
  localparam int CMD_TEXT_W = 64;
  localparam int NUM_W      = 16;
  localparam int OUT_DATA_W = BYTE_W + CMD_TEXT_W + NUM_W;

  // Character codes.
  localparam logic [BYTE_W-1:0] BYTE_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] BYTE_ZERO  = 8'd48;

  // Result kinds.
  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_LINE = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic take;      // input transaction accepted this cycle
    logic dec_step;  // one digit of the number walk
    logic finish;    // load line result and clear the stores
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_cr;     // byte at the input is a carriage return
    logic dec_last;  // the current walk step is on the first slot
  } dp_sts_t;

endpackage

/* src/scl_datapath.sv */
module scl_datapath
  import scl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  input  logic [BYTE_W-1:0]     in_byte,
  output dp_sts_t               sts,
  output logic                  res_kind,
  output logic [BYTE_W-1:0]     res_echo,
  output logic [CMD_TEXT_W-1:0] res_cmd,
  output logic [NUM_W-1:0]      res_num
);

  logic                  in_command_r;
  logic [POS_W-1:0]      position_r;
  logic [BYTE_W-1:0]     cmd_store_r [CMD_LEN];
  logic [BYTE_W-1:0]     dig_store_r [NUM_DIGITS];

  logic [DIG_IDX_W-1:0]  idx_r;
  logic [NUM_W-1:0]      weight_r;
  logic [NUM_W-1:0]      total_r;
  logic                  seen_r;

  logic                  kind_r;
  logic [BYTE_W-1:0]     echo_r;
  logic [CMD_TEXT_W-1:0] cmdtxt_r;
  logic [NUM_W-1:0]      num_r;

  logic [BYTE_W-1:0]     cur_digit;
  logic [NUM_W-1:0]      digit_val;
  logic [NUM_W-1:0]      product;
  logic [NUM_W-1:0]      weight_x10;
  logic [CMD_TEXT_W-1:0] packed_cmd;

  assign sts.is_cr    = (in_byte == BYTE_CR);
  assign sts.dec_last = (idx_r == '0);

  assign cur_digit  = dig_store_r[idx_r];
  assign digit_val  = {{(NUM_W-BYTE_W){1'b0}}, cur_digit} - {{(NUM_W-BYTE_W){1'b0}}, BYTE_ZERO};
  assign product    = digit_val * weight_r;
  assign weight_x10 = (weight_r << 3) + (weight_r << 1);

  always_comb begin
    packed_cmd = '0;
    for (int k = 0; k < CMD_LEN; k++) begin
      packed_cmd[BYTE_W*k +: BYTE_W] = cmd_store_r[k];
    end
  end

  // Line state and the two character stores.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_command_r <= 1'b1;
      position_r   <= '0;
      for (int k = 0; k < CMD_LEN; k++) cmd_store_r[k] <= '0;
      for (int k = 0; k < NUM_DIGITS; k++) dig_store_r[k] <= '0;
    end else if (cmd.finish) begin
      in_command_r <= 1'b1;
      position_r   <= '0;
      for (int k = 0; k < CMD_LEN; k++) cmd_store_r[k] <= '0;
      for (int k = 0; k < NUM_DIGITS; k++) dig_store_r[k] <= '0;
    end else if (cmd.take && !sts.is_cr) begin
      if (in_command_r) begin
        if ((position_r >= POS_W'(CMD_LEN)) || (in_byte == BYTE_SPACE)) begin
          in_command_r <= 1'b0;
          position_r   <= '0;
        end else begin
          cmd_store_r[position_r[CMD_IDX_W-1:0]] <= in_byte;
          position_r <= position_r + 1'b1;
        end
      end else if (position_r < POS_W'(NUM_DIGITS)) begin
        dig_store_r[position_r[DIG_IDX_W-1:0]] <= in_byte;
        position_r <= position_r + 1'b1;
      end
    end
  end

  // Number walk from the last digit slot to the first.
  always_ff @(posedge clk) begin
    if (cmd.take && sts.is_cr) begin
      idx_r    <= DIG_IDX_W'(NUM_DIGITS - 1);
      weight_r <= NUM_W'(1);
      total_r  <= '0;
      seen_r   <= 1'b0;
    end else if (cmd.dec_step) begin
      if (!sts.dec_last) begin
        idx_r <= idx_r - 1'b1;
      end
      if (cur_digit == '0) begin
        if (seen_r) begin
          weight_r <= weight_x10;
        end
      end else begin
        seen_r   <= 1'b1;
        total_r  <= total_r + product;
        weight_r <= weight_x10;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      kind_r   <= KIND_LINE;
      echo_r   <= '0;
      cmdtxt_r <= packed_cmd;
      num_r    <= total_r;
    end else if (cmd.take && !sts.is_cr) begin
      kind_r   <= KIND_ECHO;
      echo_r   <= in_byte;
      cmdtxt_r <= '0;
      num_r    <= '0;
    end
  end

  assign res_kind = kind_r;
  assign res_echo = echo_r;
  assign res_cmd  = cmdtxt_r;
  assign res_num  = num_r;

endmodule

/* src/scl_ctrl.sv */
module scl_ctrl
  import scl_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DONE
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;

  assign cmd.take     = in_tvalid && in_tready;
  assign cmd.dec_step = (state_r == ST_DECODE);
  assign cmd.finish   = (state_r == ST_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // A new echo or a finished line loads the output register; otherwise a
      // taken transaction empties it.
      if ((cmd.take && !sts.is_cr) || cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (cmd.take && sts.is_cr) begin
            state_r <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          if (sts.dec_last) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

/* src/serial_command_line_parser.sv */
// Channel  Direction  Handshake             Payload
// in_      slave      in_tvalid/in_tready   in_tdata: rx_byte
// out_     master     out_tvalid/out_tready out_tuser: kind;
//                                           out_tdata: echo_byte, command_text, number_value
//
// An ordinary byte is accepted and its echo lands in the output register at
// the same edge. A carriage return starts a walk over the digit store, one
// slot per cycle through a single 16 by 16 multiplier, and no next byte is
// accepted until the walk is done and the line result is loaded.
// Reset is synchronous and active low; it clears both stores and the line state.
// A stalled output holds its transaction; a new byte is accepted in the cycle
// the waiting result is taken.
module serial_command_line_parser
  import scl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] rx_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] echo_byte, [71:8] command_text,
                                            // [87:72] number_value
  output logic                  out_tuser   // [0] kind
);

  dp_cmd_t               cmd;
  dp_sts_t               sts;
  logic                  res_kind;
  logic [BYTE_W-1:0]     res_echo;
  logic [CMD_TEXT_W-1:0] res_cmd;
  logic [NUM_W-1:0]      res_num;

  // The controller sequences accept, digit walk and result load; the
  // datapath owns the stores, the number arithmetic and the output payload.
  scl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  scl_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_byte  (in_tdata),
    .sts      (sts),
    .res_kind (res_kind),
    .res_echo (res_echo),
    .res_cmd  (res_cmd),
    .res_num  (res_num)
  );

  // Fields are packed from the lowest bit up in transaction order.
  assign out_tdata = {res_num, res_cmd, res_echo};
  assign out_tuser = res_kind;

endmodule

/* tb/serial_command_line_parser_test.sv */
`timescale 1ns / 100ps

module serial_command_line_parser_test;
  import scl_pkg::*;

  // Generous ceiling: with the carriage return walks, the sender gaps and the
  // receiver stalls, the slowest legal run of about 1450 bytes stays far below
  // this.
  localparam int RUN_LIMIT     = 600000;
  localparam int TOTAL_BYTES   = 1450;
  localparam int DRAIN_CYCLES  = NUM_DIGITS + 12;

  typedef struct packed {
    logic                  kind;
    logic [BYTE_W-1:0]     echo;
    logic [CMD_TEXT_W-1:0] word;
    logic [NUM_W-1:0]      number;
  } parser_result_t;

  typedef enum int {READY_ALWAYS, READY_RANDOM, READY_BLOCKS} ready_mode_t;

  // Bytes still to be offered on the input channel, in order.
  localparam logic [BYTE_W-1:0] DIRECTED_BYTES [23] = '{
    BYTE_CR,                                           // empty line
    8'hFF, 8'h00, 8'h41, 8'h7A, 8'h7E, 8'h01, 8'h80, 8'h7F,  // full command store
    8'h58,                                             // overlong: ends the word, dropped
    8'h36, 8'h35, 8'h35, 8'h33, 8'h36, 8'hFF,          // 65536 wraps to 0, then one extra
    BYTE_CR,
    BYTE_SPACE,                                        // empty command word
    8'h00, 8'h37, 8'hFF, 8'h00,                        // leading and trailing zero bytes
    BYTE_CR
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  logic [BYTE_W-1:0] rx_bytes[$];
  parser_result_t    expected_results[$];

  // Line parser mirror state.
  logic              reading_word;
  logic [POS_W-1:0]  slot;
  logic [BYTE_W-1:0] word_chars [CMD_LEN];
  logic [BYTE_W-1:0] digit_chars [NUM_DIGITS];

  logic              in_fire;
  parser_result_t    accepted_result;
  parser_result_t    observed;
  parser_result_t    wanted;

  int                burst_left;
  int                gap_left;
  ready_mode_t       ready_mode;
  int                ready_hold;
  int                stall_left;

  int                errors;
  int                cycle_count;
  int                echoes_seen;
  int                lines_seen;
  int                long_words;
  int                dropped_digits;

  serial_command_line_parser u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // The number is read from the last digit slot back to the first. Zero bytes
  // past the last real digit are ignored; any other zero byte counts as digit 0.
  function logic [NUM_W-1:0] decoded_number();
    logic [NUM_W-1:0] weight;
    logic [NUM_W-1:0] total;
    logic             seen;
    weight = 16'd1;
    total  = '0;
    seen   = 1'b0;
    for (int k = NUM_DIGITS - 1; k >= 0; k--) begin
      if (digit_chars[k] == 8'h00) begin
        if (seen) weight = weight * 16'd10;
      end else begin
        seen   = 1'b1;
        total  = total + ({8'h00, digit_chars[k]} - {8'h00, BYTE_ZERO}) * weight;
        weight = weight * 16'd10;
      end
    end
    return total;
  endfunction

  function logic [CMD_TEXT_W-1:0] packed_word();
    logic [CMD_TEXT_W-1:0] text;
    text = '0;
    for (int k = 0; k < CMD_LEN && k < 8; k++) text[8*k +: 8] = word_chars[k];
    return text;
  endfunction

  task clear_line();
    reading_word = 1'b1;
    slot         = '0;
    foreach (word_chars[k]) word_chars[k] = '0;
    foreach (digit_chars[k]) digit_chars[k] = '0;
  endtask

  // Advances the mirror by one received byte and returns the result it causes.
  task parse_byte(input logic [BYTE_W-1:0] rx, output parser_result_t res);
    res = '0;
    if (rx == BYTE_CR) begin
      res.kind   = KIND_LINE;
      res.word   = packed_word();
      res.number = decoded_number();
      clear_line();
    end else begin
      res.kind = KIND_ECHO;
      res.echo = rx;
      if (reading_word) begin
        if (slot >= CMD_LEN || rx == BYTE_SPACE) begin
          if (slot >= CMD_LEN) long_words++;
          reading_word = 1'b0;
          slot         = '0;
        end else begin
          word_chars[slot[CMD_IDX_W-1:0]] = rx;
          slot                            = slot + 1'b1;
        end
      end else if (slot < NUM_DIGITS) begin
        digit_chars[slot[DIG_IDX_W-1:0]] = rx;
        slot                             = slot + 1'b1;
      end else begin
        dropped_digits++;
      end
    end
  endtask

  // Any byte that neither ends the line nor ends the command word.
  function logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == BYTE_CR || b == BYTE_SPACE);
    return b;
  endfunction

  // Builds one line: mostly well formed words and numbers with random
  // content, now and then raw noise or a line with no carriage return.
  task queue_random_line();
    int form;
    int word_len;
    int digit_len;
    form = $urandom_range(0, 9);
    if (form == 0) begin
      repeat ($urandom_range(1, 12)) rx_bytes.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 1) rx_bytes.push_back(BYTE_CR);
    end else begin
      word_len = ($urandom_range(0, 4) == 0) ? $urandom_range(CMD_LEN, CMD_LEN + 3)
                                             : $urandom_range(0, CMD_LEN);
      repeat (word_len) begin
        if ($urandom_range(0, 3) == 0) rx_bytes.push_back(plain_byte());
        else rx_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
      end
      if ($urandom_range(0, 5) != 0) begin
        if (word_len < CMD_LEN || $urandom_range(0, 1) == 1) rx_bytes.push_back(BYTE_SPACE);
        else rx_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
        digit_len = $urandom_range(0, NUM_DIGITS + 2);
        repeat (digit_len) begin
          case ($urandom_range(0, 7))
            0:       rx_bytes.push_back(plain_byte());
            1:       rx_bytes.push_back(8'h00);
            default: rx_bytes.push_back(BYTE_ZERO + 8'($urandom_range(0, 9)));
          endcase
        end
      end
      if ($urandom_range(0, 19) != 0) rx_bytes.push_back(BYTE_CR);
    end
  endtask

  // Input side: every accepted transaction is run through the mirror at the
  // edge that accepts it, so the expectation is queued in acceptance order.
  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      parse_byte(in_tdata, accepted_result);
      expected_results.push_back(accepted_result);
    end
  end

  // Sender: bursts of back to back bytes separated by idle gaps. A byte that
  // has been offered is held until it is taken.
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (rx_bytes.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= rx_bytes.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 60);
          case ($urandom_range(0, 3))
            0:       gap_left = 0;
            1:       gap_left = $urandom_range(8, 30);
            default: gap_left = $urandom_range(1, 6);
          endcase
        end else begin
          burst_left--;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: switches every so often between always ready, a random ready
  // each cycle (two times in three), and occasional blocks of stall cycles.
  always @(negedge clk) begin
    if (ready_hold == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 2));
      ready_hold = $urandom_range(64, 256);
    end else begin
      ready_hold--;
    end
    case (ready_mode)
      READY_ALWAYS: out_tready <= 1'b1;
      READY_RANDOM: out_tready <= ($urandom_range(0, 2) != 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 11);
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    endcase
  end

  // Result side: each output transaction is checked field by field against
  // the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      observed.kind   = out_tuser;
      observed.echo   = out_tdata[7:0];
      observed.word   = out_tdata[71:8];
      observed.number = out_tdata[87:72];
      if (observed.kind == KIND_LINE) lines_seen++;
      else echoes_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, kind %0d data %h", $time,
                 out_tuser, out_tdata);
        errors++;
      end else begin
        wanted = expected_results.pop_front();
        if (observed.kind !== wanted.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, wanted.kind, observed.kind);
          errors++;
        end
        if (observed.echo !== wanted.echo) begin
          $display("%0t: echo_byte expected %h actual %h", $time, wanted.echo, observed.echo);
          errors++;
        end
        if (observed.word !== wanted.word) begin
          $display("%0t: command_text expected %h actual %h", $time, wanted.word,
                   observed.word);
          errors++;
        end
        if (observed.number !== wanted.number) begin
          $display("%0t: number_value expected %0d actual %0d", $time, wanted.number,
                   observed.number);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("%0t: timed out with %0d bytes unsent and %0d results outstanding", $time,
               rx_bytes.size(), expected_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    in_fire        = 1'b0;
    burst_left     = 1;
    gap_left       = 0;
    ready_mode     = READY_ALWAYS;
    ready_hold     = 0;
    stall_left     = 0;
    errors         = 0;
    cycle_count    = 0;
    echoes_seen    = 0;
    lines_seen     = 0;
    long_words     = 0;
    dropped_digits = 0;
    clear_line();

    foreach (DIRECTED_BYTES[k]) rx_bytes.push_back(DIRECTED_BYTES[k]);
    while (rx_bytes.size() < TOTAL_BYTES) queue_random_line();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: all bytes taken, the last one no longer offered, every result seen.
    while (rx_bytes.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Parsed %0d lines and %0d echoed bytes under random gaps and stalls.",
             lines_seen, echoes_seen);
    $display("Command words cut at full length: %0d, digit bytes past the store: %0d.",
             long_words, dropped_digits);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
